FILE: hdl/exp_hyperbolic_cordic_macros.svh
// Assertion helpers for the exponential unit
`ifndef EXP_HYPERBOLIC_CORDIC_MACROS_SVH
`define EXP_HYPERBOLIC_CORDIC_MACROS_SVH

`ifndef SYNTHESIS

`define EHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ehc: implication check failed");

`define EHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ehc: next-cycle check failed");

`else

`define EHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define EHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/ehc_pkg.sv
`timescale 1ns / 1ps

package ehc_pkg;

    localparam int XW_IN = 18;
    localparam int OW = 20;
    localparam int KW = 5;
    localparam int K_MIN = -12;

    localparam int RR_FRAC = 24;
    localparam logic signed [25:0] RR_LN2 = 26'sd11629079;
    localparam logic signed [25:0] RR_INV_LN2 = 26'sd24204406;

    localparam int REP_A = 4;
    localparam int REP_B = 13;
    localparam int MAX_SHIFT = 20;

    localparam int SERIES_FRAC = 62;
    localparam int SERIES_TERMS = 31;
    localparam longint unsigned ODD_DIV [SERIES_TERMS] = '{
        64'd1, 64'd3, 64'd5, 64'd7, 64'd9, 64'd11, 64'd13, 64'd15,
        64'd17, 64'd19, 64'd21, 64'd23, 64'd25, 64'd27, 64'd29, 64'd31,
        64'd33, 64'd35, 64'd37, 64'd39, 64'd41, 64'd43, 64'd45, 64'd47,
        64'd49, 64'd51, 64'd53, 64'd55, 64'd57, 64'd59, 64'd61
    };

    localparam longint unsigned GAIN_NUM = 64'd1207497067763072;
    localparam longint unsigned GAIN_DEN = 64'd1000000000000000;

    typedef struct packed {
        logic                 below;
        logic signed [KW-1:0] k;
    } t_side;

    // atanh(2^-i) with fb fraction bits, truncated
    function automatic longint unsigned atanh_pow2(int i, int fb);
        longint unsigned acc;
        int sh;
        acc = 64'd0;
        for (int n = 0; n < SERIES_TERMS; n++) begin
            sh = i * (2 * n + 1);
            if (sh <= SERIES_FRAC) begin
                acc += (64'd1 << (SERIES_FRAC - sh)) / ODD_DIV[n];
            end
        end
        return acc >> (SERIES_FRAC - fb);
    endfunction

    // CORDIC start value with fb fraction bits, truncated
    function automatic longint unsigned gain_const(int fb);
        longint unsigned rem;
        longint unsigned f;
        rem = GAIN_NUM - GAIN_DEN;
        f = 64'd0;
        for (int b = 0; b < fb; b++) begin
            rem = rem << 1;
            f = f << 1;
            if (rem >= GAIN_DEN) begin
                f = f | 64'd1;
                rem = rem - GAIN_DEN;
            end
        end
        return (64'd1 << fb) + f;
    endfunction

    // shift used by iteration j, with the repeated shifts run twice
    function automatic int iter_shift(int j);
        int cnt;
        int res;
        cnt = 0;
        res = 1;
        for (int i = 1; i <= MAX_SHIFT; i++) begin
            if (cnt == j) res = i;
            cnt++;
            if (i == REP_A || i == REP_B) begin
                if (cnt == j) res = i;
                cnt++;
            end
        end
        return res;
    endfunction

endpackage

FILE: hdl/ehc_if.sv
`timescale 1ns / 1ps

interface ehc_in_if import ehc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [XW_IN-1:0] x_in;

    modport source (output valid, output x_in, input ready);
    modport sink (input valid, input x_in, output ready);
endinterface

interface ehc_out_if import ehc_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [OW-1:0] exp_value;

    modport source (output valid, output exp_value, input ready);
    modport sink (input valid, input exp_value, output ready);
endinterface

FILE: hdl/ehc_cordic_stage.sv
`timescale 1ns / 1ps

module ehc_cordic_stage import ehc_pkg::*; #(
    parameter int FRAC_BITS = 24,
    parameter int SHIFT = 1
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [FRAC_BITS+3:0] i_x,
    input  logic signed [FRAC_BITS+3:0] i_y,
    input  logic signed [FRAC_BITS+3:0] i_z,
    output logic signed [FRAC_BITS+3:0] o_x,
    output logic signed [FRAC_BITS+3:0] o_y,
    output logic signed [FRAC_BITS+3:0] o_z
);

    localparam int VW = FRAC_BITS + 4;
    localparam logic signed [VW-1:0] Angle = VW'(atanh_pow2(SHIFT, FRAC_BITS));

    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    logic signed [VW-1:0] n_x;
    logic signed [VW-1:0] n_y;
    logic signed [VW-1:0] n_z;
    logic signed [VW-1:0] r_x;
    logic signed [VW-1:0] r_y;
    logic signed [VW-1:0] r_z;

    always_comb begin
        xs = i_x >>> SHIFT;
        ys = i_y >>> SHIFT;
        if (!i_z[VW-1]) begin
            n_x = i_x + ys;
            n_y = i_y + xs;
            n_z = i_z - Angle;
        end else begin
            n_x = i_x - ys;
            n_y = i_y - xs;
            n_z = i_z + Angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: hdl/exp_hyperbolic_cordic.sv
// exp(x) for a stream of signed fixed-point samples (IN_FRAC_BITS fraction bits), result in
// unsigned Q4.16. Positive samples give 1.0, samples below -8 give 0. One sample per clock
// without backpressure: every stage is a register. The pipeline is the CORDIC chain, one
// iteration per stage with the shifts 4 and 13 repeated, plus a multiply stage for k, a
// stage for the remainder, and two output stages. Each stage holds its beat when it is full
// and the next one cannot advance, so bubbles close up and backpressure stops the input
// only when every stage is occupied.
`timescale 1ns / 1ps

`include "exp_hyperbolic_cordic_macros.svh"

module exp_hyperbolic_cordic import ehc_pkg::*; #(
    parameter int STAGES = 16,
    parameter int FRAC_BITS = 24,
    parameter int IN_FRAC_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ehc_in_if.sink    i_smp,
    ehc_out_if.source o_exp
);

    localparam int NIter = STAGES + ((STAGES >= REP_A) ? 1 : 0) + ((STAGES >= REP_B) ? 1 : 0);
    localparam int NS = NIter + 4;
    localparam int VW = FRAC_BITS + 4;
    localparam int RW = 31;
    localparam int TW = RW + FRAC_BITS;
    localparam int PW = XW_IN + 26;
    localparam int XMin = -(8 << IN_FRAC_BITS);
    localparam logic signed [VW-1:0] Gain = VW'(gain_const(FRAC_BITS));
    localparam logic signed [VW:0] EOff = (VW+1)'(1) <<< (FRAC_BITS - 18);

    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;
    t_side         r_side [NS];

    // front: clamp and k
    logic                    n_below;
    logic signed [XW_IN-1:0] n_xc;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_sh;
    logic signed [XW_IN-1:0] r_xc;

    // remainder
    logic signed [RW-1:0] xw;
    logic signed [RW-1:0] kl;
    logic signed [RW-1:0] rr;
    logic signed [TW-1:0] rt;
    logic signed [VW-1:0] n_z;
    logic signed [VW-1:0] r_z;

    // CORDIC chain
    logic signed [VW-1:0] cx [NIter+1];
    logic signed [VW-1:0] cy [NIter+1];
    logic signed [VW-1:0] cz [NIter+1];

    // output stages
    logic signed [VW:0] e_sum;
    logic signed [VW:0] e_pos;
    logic [OW-1:0]      n_mant;
    logic [OW-1:0]      r_mant;
    logic [KW-1:0]      nk;
    logic [OW-1:0]      n_exp;
    logic [OW-1:0]      r_exp;

    // advance a stage when it is empty or its successor advances
    assign rdy[NS] = o_exp.ready;
    for (genvar s = 0; s < NS; s++) begin : g_rdy
        assign rdy[s] = !r_vld[s] || rdy[s+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_smp.valid;
            for (int s = 1; s < NS; s++) begin
                if (rdy[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_side[0].below <= n_below;
            r_side[0].k <= prod_sh[KW-1:0];
        end
        for (int s = 1; s < NS; s++) begin
            if (rdy[s]) r_side[s] <= r_side[s-1];
        end
    end

    always_comb begin
        n_below = i_smp.x_in < XMin;
        n_xc = i_smp.x_in[XW_IN-1] ? i_smp.x_in : '0;
        prod = PW'(n_xc) * PW'(RR_INV_LN2);
        prod_sh = prod >>> (IN_FRAC_BITS + RR_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_xc <= n_xc;
        end
    end

    always_comb begin
        xw = RW'(r_xc) <<< (RR_FRAC - IN_FRAC_BITS);
        kl = RW'(r_side[0].k) * RW'(RR_LN2);
        rr = xw - kl;
        rt = TW'(rr) <<< FRAC_BITS;
        n_z = VW'(rt >>> RR_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) r_z <= n_z;
    end

    assign cx[0] = Gain;
    assign cy[0] = '0;
    assign cz[0] = r_z;

    for (genvar j = 0; j < NIter; j++) begin : g_iter
        ehc_cordic_stage #(
            .FRAC_BITS(FRAC_BITS),
            .SHIFT(iter_shift(j))
        ) u_stage (
            .i_clk(i_clk),
            .i_en(rdy[2+j]),
            .i_x(cx[j]),
            .i_y(cy[j]),
            .i_z(cz[j]),
            .o_x(cx[j+1]),
            .o_y(cy[j+1]),
            .o_z(cz[j+1])
        );
    end

    always_comb begin
        e_sum = (VW+1)'(cx[NIter]) + (VW+1)'(cy[NIter]);
        e_pos = e_sum[VW] ? '0 : e_sum;
        e_pos = e_pos + EOff;
        n_mant = e_pos[FRAC_BITS+3 -: OW];
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NS-2]) r_mant <= n_mant;
    end

    always_comb begin
        nk = -r_side[NS-2].k;
        if (r_side[NS-2].below) begin
            n_exp = '0;
        end else if (r_side[NS-2].k[KW-1]) begin
            n_exp = (nk >= OW) ? '0 : (r_mant >> nk);
        end else begin
            n_exp = r_mant;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NS-1]) r_exp <= n_exp;
    end

    assign i_smp.ready = rdy[0];
    assign o_exp.valid = r_vld[NS-1];
    assign o_exp.exp_value = r_exp;

    `EHC_ASSERT_NXT(a_accept_fills, i_clk, i_rst_n, i_smp.valid && i_smp.ready, r_vld[0])
    `EHC_ASSERT_IMP(a_k_range, i_clk, i_rst_n, r_vld[1] && !r_side[1].below,
                    r_side[1].k <= 0 && r_side[1].k >= K_MIN)
    `EHC_ASSERT_NXT(a_mant_hold, i_clk, i_rst_n, r_vld[NS-2] && !rdy[NS-1],
                    r_vld[NS-2] && $stable(r_mant))

endmodule
